FILE: rtl/csrf_pkg.sv
// Package of the cross stencil RGB filter: sizes, register codes and payload types.
package csrf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int CH_W       = 8;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int GAIN_W     = 13;
  // any effective width (at most MAX_WIDTH) times any height the registers can hold
  localparam int POS_W      = ADDR_W + HEIGHT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SIDE_W     = CH_W + 2;
  localparam int ACC_W      = SIDE_W + GAIN_W + 3;

  localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRAL_GAIN = 2'd0,
    CFG_SIDE_GAIN    = 2'd1,
    CFG_FRAME_WIDTH  = 2'd2,
    CFG_FRAME_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_e;

  typedef struct packed {
    logic            req_type;
    logic [CH_W-1:0] pix_red;
    logic [CH_W-1:0] pix_green;
    logic [CH_W-1:0] pix_blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_end;
  } out_item_t;

  // channel 0 red, 1 green, 2 blue
  typedef logic [2:0][CH_W-1:0] pixel_t;

  // neighbours that fall outside the frame take the center pixel
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } border_t;

endpackage

FILE: rtl/cross_stencil_rgb_filter_unit.sv
// Five-point cross filter over an RGB raster stream with two line stores.
// Throughput: one item per cycle unless the divider or a stalled output holds the input.
// The line store is read at the input transfer; the result register and out_valid_o load
// when stage 1 advances. Result k of a frame is caused by item k + frame_width + 1.
// A frame_width write starts a divide of the output position; input stalls meanwhile.
// rst_ni clears counters, window, gains and geometry; line stores are not cleared.
module cross_stencil_rgb_filter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  csrf_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output csrf_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [csrf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [csrf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import csrf_pkg::*;

  // configuration
  logic signed [GAIN_W-1:0] cgain_q, sgain_q;
  logic [WIDTH_W-1:0]       fwidth_q;
  logic [HEIGHT_W-1:0]      fheight_q;

  // stream counters
  logic [ADDR_W-1:0]   in_col_q, in_col_d;
  logic [HEIGHT_W-1:0] in_row_q, in_row_d;
  logic [POS_W-1:0]    out_pos_q, out_pos_d;
  logic [ADDR_W-1:0]   out_col_q, out_col_d;
  logic [HEIGHT_W-1:0] out_row_q, out_row_d;

  // position divider after a width change
  logic [4:0]          div_cnt_q;
  logic [WIDTH_W-1:0]  div_rem_q, div_rem_d, div_trial;
  logic [POS_W-1:0]    div_quo_q, div_quo_d;
  logic                div_bit;

  // line stores: upper row in the high half, middle row in the low half
  logic [2*$bits(pixel_t)-1:0] line_mem [MAX_WIDTH];
  logic [2*$bits(pixel_t)-1:0] mem_rd_q;

  // stage 1
  logic              s1_valid_q;
  pixel_t            s1_px_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic              s1_emit_q, s1_last_q;
  border_t           s1_bord_q;
  logic              s1_fwd_q;
  pixel_t            s1_fwd_mid_q, s1_fwd_up_q;

  pixel_t            win_q [4];   // 0: newest, 1: center, 2: left, 3: up

  logic              out_valid_q;
  out_item_t         out_q;

  // accept side
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [ADDR_W-1:0]   col_cur;
  logic [WIDTH_W-1:0]  col_inc;
  logic                draining, drop, accept, live, q_emit, overflow, result, last;
  logic                busy, out_free, s1_go, bypass;
  pixel_t              px_in;
  border_t             bord_d;

  // stage 1 datapath
  pixel_t              mid_old, up_old, c_px, u_px, d_px, l_px, r_px;
  logic [2:0][CH_W-1:0] filt;

  function automatic logic [CH_W-1:0] filter_ch(logic [CH_W-1:0] c, logic [SIDE_W-1:0] s,
                                               logic signed [GAIN_W-1:0] cg,
                                               logic signed [GAIN_W-1:0] sg);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rnd;
    logic [CH_W-1:0]         res;
    acc = $signed({1'b0, c}) * cg + $signed({1'b0, s}) * sg;
    rnd = (acc + ACC_W'(128)) >>> 8;
    if (acc < 0) begin
      res = '0;
    end else if (rnd > $signed({{(ACC_W-CH_W){1'b0}}, CH_MAX})) begin
      res = CH_MAX;
    end else begin
      res = rnd[CH_W-1:0];
    end
    return res;
  endfunction

  assign busy     = div_cnt_q != '0;
  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_go    = s1_valid_q && (!s1_emit_q || out_free);
  assign in_stall_o = busy || (s1_valid_q && !s1_go);
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    if (fwidth_q == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (fwidth_q > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = fwidth_q;
    end
    h_eff = (fheight_q == '0) ? HEIGHT_W'(1) : fheight_q;
  end

  always_comb begin
    col_cur  = ({1'b0, in_col_q} >= w_eff) ? '0 : in_col_q;
    col_inc  = {1'b0, col_cur} + WIDTH_W'(1);
    draining = in_row_q >= h_eff;
    drop     = !draining && (in_data_i.req_type == REQ_DRAIN);
    live     = accept && !drop;
    px_in[0] = draining ? '0 : in_data_i.pix_red;
    px_in[1] = draining ? '0 : in_data_i.pix_green;
    px_in[2] = draining ? '0 : in_data_i.pix_blue;
    // the window is full once the stream is one row and one pixel ahead
    q_emit   = draining || (in_row_q >= HEIGHT_W'(2)) ||
               ((in_row_q == HEIGHT_W'(1)) && (col_cur != '0));
    overflow = q_emit && (out_row_q >= h_eff);
    result   = q_emit && !overflow;
    last     = result && (out_row_q == h_eff - HEIGHT_W'(1)) &&
               ({1'b0, out_col_q} == w_eff - WIDTH_W'(1));
    bord_d.up    = out_row_q == '0;
    bord_d.down  = (out_row_q + HEIGHT_W'(1)) >= h_eff;
    bord_d.left  = out_col_q == '0;
    bord_d.right = ({1'b0, out_col_q} + WIDTH_W'(1)) >= w_eff;
    bypass   = s1_go && (s1_addr_q == col_cur);

    in_col_d  = (col_inc >= w_eff) ? '0 : col_inc[ADDR_W-1:0];
    in_row_d  = (col_inc >= w_eff && !draining) ? in_row_q + HEIGHT_W'(1) : in_row_q;
    out_pos_d = out_pos_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (overflow || last) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_pos_d = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (result) begin
      out_pos_d = out_pos_q + POS_W'(1);
      if (bord_d.right) begin
        out_col_d = '0;
        out_row_d = out_row_q + HEIGHT_W'(1);
      end else begin
        out_col_d = out_col_q + ADDR_W'(1);
      end
    end
  end

  // restoring divide, one quotient bit per cycle
  always_comb begin
    div_trial = {div_rem_q[WIDTH_W-2:0], div_quo_q[POS_W-1]};
    div_bit   = div_trial >= w_eff;
    div_rem_d = div_bit ? div_trial - w_eff : div_trial;
    div_quo_d = {div_quo_q[POS_W-2:0], div_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cgain_q   <= GAIN_W'(256);
      sgain_q   <= '0;
      fwidth_q  <= WIDTH_W'(MAX_WIDTH);
      fheight_q <= HEIGHT_W'(1080);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_pos_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      div_cnt_q <= '0;
      div_rem_q <= '0;
      div_quo_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CENTRAL_GAIN: cgain_q   <= $signed(cfg_wdata_i[GAIN_W-1:0]);
          CFG_SIDE_GAIN:    sgain_q   <= $signed(cfg_wdata_i[GAIN_W-1:0]);
          CFG_FRAME_WIDTH:  fwidth_q  <= cfg_wdata_i[WIDTH_W-1:0];
          CFG_FRAME_HEIGHT: fheight_q <= cfg_wdata_i[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (cfg_we_i && cfg_idx_i == CFG_FRAME_WIDTH) begin
        div_cnt_q <= 5'(POS_W);
        div_rem_q <= '0;
        div_quo_q <= out_pos_q;
      end else if (busy) begin
        div_cnt_q <= div_cnt_q - 5'd1;
        div_rem_q <= div_rem_d;
        div_quo_q <= div_quo_d;
        if (div_cnt_q == 5'd1) begin
          out_col_q <= div_rem_d[ADDR_W-1:0];
          out_row_q <= (|div_quo_d[POS_W-1:HEIGHT_W]) ? '1 : div_quo_d[HEIGHT_W-1:0];
        end
      end
      if (live) begin
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_pos_q <= out_pos_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
      end
    end
  end

  // stage 1 sources: a store read that races the write of the same column is forwarded
  always_comb begin
    mid_old = s1_fwd_q ? s1_fwd_mid_q : mem_rd_q[$bits(pixel_t)-1:0];
    up_old  = s1_fwd_q ? s1_fwd_up_q  : mem_rd_q[2*$bits(pixel_t)-1:$bits(pixel_t)];
    c_px = win_q[1];
    u_px = s1_bord_q.up    ? c_px : win_q[3];
    d_px = s1_bord_q.down  ? c_px : win_q[0];
    l_px = s1_bord_q.left  ? c_px : win_q[2];
    r_px = s1_bord_q.right ? c_px : mid_old;
    for (int i = 0; i < 3; i++) begin
      filt[i] = filter_ch(c_px[i],
                          SIDE_W'(u_px[i]) + SIDE_W'(d_px[i]) +
                          SIDE_W'(l_px[i]) + SIDE_W'(r_px[i]),
                          cgain_q, sgain_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (live) begin
      mem_rd_q <= line_mem[col_cur];
    end
    if (s1_go) begin
      line_mem[s1_addr_q] <= {mid_old, s1_px_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (live) begin
      s1_px_q      <= px_in;
      s1_addr_q    <= col_cur;
      s1_emit_q    <= result;
      s1_last_q    <= last;
      s1_bord_q    <= bord_d;
      s1_fwd_q     <= bypass;
      s1_fwd_mid_q <= s1_px_q;
      s1_fwd_up_q  <= mid_old;
    end
    if (s1_go && s1_emit_q) begin
      out_q.out_red   <= filt[0];
      out_q.out_green <= filt[1];
      out_q.out_blue  <= filt[2];
      out_q.frame_end <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (live) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        win_q[0] <= s1_px_q;
        win_q[1] <= mid_old;
        win_q[2] <= win_q[1];
        win_q[3] <= up_old;
      end
      if (s1_go && s1_emit_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sim/csrf_frame_checker.sv
// Checker for the cross stencil filter: follows each frame, predicts every result, compares.
`timescale 1ns / 100ps
module csrf_frame_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  csrf_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  csrf_pkg::out_item_t             out_data_i,
  input  logic                            cfg_we_i,
  input  logic [csrf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [csrf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import csrf_pkg::*;

  int                  central_gain;
  int                  side_gain;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;

  pixel_t      upper_line [MAX_WIDTH];
  pixel_t      middle_line [MAX_WIDTH];
  pixel_t      taps [4];  // newest, center, left, up
  int unsigned in_col;
  int unsigned in_row;
  int unsigned out_pos;

  out_item_t expected_pixels [$];
  int        fail_count = 0;
  int        pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic clear_state();
    central_gain = 256;
    side_gain    = 0;
    width_reg    = 12'd2048;
    height_reg   = 13'd1080;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 4; i++) taps[i] = '0;
    in_col  = 0;
    in_row  = 0;
    out_pos = 0;
    expected_pixels.delete();
  endtask

  function automatic logic [CH_W-1:0] weigh_channel(input int cen, input int sides);
    longint acc;
    acc = longint'(cen) * longint'(central_gain) + longint'(sides) * longint'(side_gain);
    if (acc < 0) return '0;
    acc = (acc + 128) >>> 8;
    if (acc > longint'(CH_MAX)) return CH_MAX;
    return acc[CH_W-1:0];
  endfunction

  task automatic filter_step(input in_item_t item);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned pos_in;
    int unsigned x;
    int unsigned r;
    int unsigned c;
    logic        draining;
    pixel_t      px;
    pixel_t      mid_old;
    pixel_t      up_old;
    pixel_t      center;
    pixel_t      nb_up;
    pixel_t      nb_down;
    pixel_t      nb_left;
    pixel_t      nb_right;
    pixel_t      filt;
    out_item_t   res;

    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    total = w * h;
    if (in_col >= w) in_col = 0;
    draining = (in_row >= h);
    // drain requests while pixels are still due are dropped
    if (!draining && item.req_type == REQ_DRAIN) return;

    px = '0;
    if (!draining) begin
      px[0] = item.pix_red;
      px[1] = item.pix_green;
      px[2] = item.pix_blue;
    end

    pos_in  = in_row * w + in_col;
    x       = in_col;
    mid_old = middle_line[x];
    up_old  = upper_line[x];

    nb_down  = taps[0];
    center   = taps[1];
    nb_left  = taps[2];
    nb_up    = taps[3];
    nb_right = mid_old;

    taps[2] = taps[1];
    taps[1] = mid_old;
    taps[3] = up_old;
    taps[0] = px;
    upper_line[x]  = mid_old;
    middle_line[x] = px;

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      if (!draining) in_row++;
    end

    if (!(draining || pos_in >= w + 1)) return;
    if (out_pos >= total) begin
      in_row  = 0;
      in_col  = 0;
      out_pos = 0;
      return;
    end

    r = out_pos / w;
    c = out_pos % w;
    if (r == 0) nb_up = center;
    if (r + 1 >= h) nb_down = center;
    if (c == 0) nb_left = center;
    if (c + 1 >= w) nb_right = center;
    for (int i = 0; i < 3; i++) begin
      filt[i] = weigh_channel(int'(center[i]), int'(nb_up[i]) + int'(nb_down[i]) +
                              int'(nb_left[i]) + int'(nb_right[i]));
    end
    res.out_red   = filt[0];
    res.out_green = filt[1];
    res.out_blue  = filt[2];
    res.frame_end = (out_pos == total - 1);
    if (res.frame_end) begin
      in_row  = 0;
      in_col  = 0;
      out_pos = 0;
    end else begin
      out_pos++;
    end
    expected_pixels.push_back(res);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_pixels.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: result with none expected: r=%0d g=%0d b=%0d end=%0b", $time,
                 got.out_red, got.out_green, got.out_blue, got.frame_end);
      end
      return;
    end
    want = expected_pixels.pop_front();
    if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
        got.out_blue !== want.out_blue || got.frame_end !== want.frame_end) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: mismatch: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                 $time, want.out_red, want.out_green, want.out_blue, want.frame_end,
                 got.out_red, got.out_green, got.out_blue, got.frame_end);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CENTRAL_GAIN: central_gain = int'($signed(cfg_wdata_i));
          CFG_SIDE_GAIN:    side_gain = int'($signed(cfg_wdata_i));
          CFG_FRAME_WIDTH:  width_reg = cfg_wdata_i[WIDTH_W-1:0];
          CFG_FRAME_HEIGHT: height_reg = cfg_wdata_i[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      // a result leaving now was caused by an earlier transfer
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) filter_step(in_data_i);
    end
    pending = expected_pixels.size();
  end

endmodule

FILE: sim/cross_stencil_rgb_filter_unit_test.sv
// Testbench top for the cross stencil filter: stimulus, idling, timeout and verdict.
`timescale 1ns / 100ps
module cross_stencil_rgb_filter_unit_test;
  import csrf_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int TALL_ROWS     = 300;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  in_item_t              req_data = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  out_item_t             res_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int          fail_count;
  int          pending;
  int unsigned send_idle_pct = 26;
  int unsigned stall_pct = 48;
  int unsigned items_sent = 0;

  cross_stencil_rgb_filter_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  csrf_frame_checker frame_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_stall_i   (req_stall),
    .in_data_i    (req_data),
    .out_valid_i  (res_valid),
    .out_stall_i  (res_stall),
    .out_data_i   (res_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(8_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(7))
      0: return '0;
      1: return CH_MAX;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.req_type  = 1'($urandom_range(1));
    it.pix_red   = rand_channel();
    it.pix_green = rand_channel();
    it.pix_blue  = rand_channel();
    return it;
  endfunction

  function automatic in_item_t pix(input int r, input int g, input int b);
    in_item_t it;
    it.req_type  = REQ_PIXEL;
    it.pix_red   = CH_W'(r);
    it.pix_green = CH_W'(g);
    it.pix_blue  = CH_W'(b);
    return it;
  endfunction

  function automatic in_item_t rand_pix();
    return pix(int'(rand_channel()), int'(rand_channel()), int'(rand_channel()));
  endfunction

  function automatic in_item_t drain_req();
    in_item_t it;
    it          = rand_item();
    it.req_type = REQ_DRAIN;
    return it;
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  // hold off the sender until every predicted result has left the block
  task automatic hold_until_drained();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_filter(input int cg, input int sg, input int wv, input int hv);
    cfg_idx_e                regs [4];
    logic [CFG_DATA_W-1:0]   vals [4];
    regs = '{CFG_CENTRAL_GAIN, CFG_SIDE_GAIN, CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT};
    vals[0] = cg[CFG_DATA_W-1:0];
    vals[1] = sg[CFG_DATA_W-1:0];
    vals[2] = wv[CFG_DATA_W-1:0];
    vals[3] = hv[CFG_DATA_W-1:0];
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_gain(input int typical, input int spread);
    if ($urandom_range(3) == 0) return int'($urandom_range(8191)) - 4096;
    return typical + int'($urandom_range(2 * spread)) - spread;
  endfunction

  // one whole frame with stray drains, then the flush that empties it
  task automatic send_frame(input int wv, input int hv);
    int w;
    int h;
    w = (wv < 1) ? 1 : ((wv > MAX_WIDTH) ? MAX_WIDTH : wv);
    h = (hv < 1) ? 1 : hv;
    for (int n = 0; n < w * h; n++) begin
      if ($urandom_range(19) == 0) send_item(drain_req());
      send_item(rand_pix());
    end
    // after the last pixel either request type acts as a flush step
    for (int n = 0; n <= w; n++) send_item(rand_item());
    if ($urandom_range(3) == 0) send_item(drain_req());
  endtask

  initial begin
    int unsigned small_items;
    int unsigned mark;
    int          wv;
    int          hv;
    bit          tall_done;

    small_items = 0;
    tall_done   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // channel extremes, a stray drain, a mid-frame hold and pixels during the flush
    set_filter(512, -64, 3, 2);
    send_item(pix(0, 0, 0));
    send_item(pix(255, 255, 255));
    send_item(drain_req());
    send_item(pix(255, 0, 0));
    hold_until_drained();
    send_item(pix(0, 255, 0));
    send_item(pix(0, 0, 255));
    send_item(pix(1, 128, 254));
    send_item(pix(9, 9, 9));
    send_item(drain_req());
    send_item(drain_req());
    send_item(pix(200, 1, 3));
    wait_idle();

    // zero geometry acts as a single pixel; negative sum clamps to zero
    set_filter(4095, -4096, 0, 0);
    send_item(pix(255, 255, 255));
    send_item(drain_req());
    send_item(drain_req());
    wait_idle();

    // inverted gains saturate at the top
    set_filter(-4096, 4095, 2, 2);
    send_item(pix(0, 0, 0));
    send_item(pix(255, 255, 255));
    send_item(pix(255, 128, 0));
    send_item(pix(0, 255, 255));
    repeat (3) send_item(drain_req());
    wait_idle();

    // narrower row mid-frame re-splits the output position; a lower height
    // then leaves the position past the frame and the counters restart
    set_filter(300, 20, 5, 4);
    repeat (12) send_item(rand_pix());
    wait_idle();
    set_filter(300, 20, 3, 4);
    repeat (4) send_item(rand_pix());
    wait_idle();
    set_filter(300, 20, 3, 3);
    send_item(drain_req());
    wait_idle();

    while (small_items < RANDOM_ITEMS) begin
      if (small_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 26;
        stall_pct     = 48;
      end else if (small_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 48;
        stall_pct     = 26;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      mark = items_sent;
      if (!tall_done && send_idle_pct == 48) begin
        set_filter(pick_gain(256, 64), pick_gain(0, 80), 1, TALL_ROWS);
        send_frame(1, TALL_ROWS);
        tall_done = 1'b1;
      end else begin
        case ($urandom_range(15))
          0:       wv = 0;
          1:       wv = $urandom_range(64, 16);
          default: wv = $urandom_range(10, 1);
        endcase
        case ($urandom_range(15))
          0:       hv = 0;
          1:       hv = $urandom_range(20, 7);
          default: hv = $urandom_range(6, 1);
        endcase
        set_filter(pick_gain(256, 128), pick_gain(0, 80), wv, hv);
        send_frame(wv, hv);
      end
      small_items += items_sent - mark;
      wait_idle();
    end

    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/csrf_pkg.sv
rtl/cross_stencil_rgb_filter_unit.sv
sim/csrf_frame_checker.sv
sim/cross_stencil_rgb_filter_unit_test.sv
